@@ rtl/necir_pkg.sv @@
// Shared types and constants for the NEC IR frame decoder.
`default_nettype none

package necir_pkg;

    localparam int RUN_W    = 11;
    localparam int BCNT_W   = 6;
    localparam int DATA_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int REP_W    = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [RUN_W-1:0] RUN_MAX      = 11'd2047;
    localparam logic [RUN_W-1:0] LEAD_MIN     = 11'd80;
    localparam logic [RUN_W-1:0] LEAD_MAX     = 11'd100;
    localparam logic [RUN_W-1:0] ZERO_MIN     = 11'd3;
    localparam logic [RUN_W-1:0] ZERO_MAX     = 11'd8;
    localparam logic [RUN_W-1:0] ONE_MIN      = 11'd15;
    localparam logic [RUN_W-1:0] ONE_MAX      = 11'd19;
    localparam logic [RUN_W-1:0] RPT_MIN      = 11'd20;
    localparam logic [RUN_W-1:0] RPT_MAX      = 11'd25;
    localparam logic [RUN_W-1:0] HDR_MIN      = 11'd42;
    localparam logic [RUN_W-1:0] HDR_MAX      = 11'd48;
    localparam logic [RUN_W-1:0] TIMEOUT_RST  = 11'd1200;
    localparam logic [BCNT_W-1:0] BITS_FULL   = 6'd32;
    localparam logic [REP_W-1:0] REP_MAX      = 8'd255;

    // register index, taken from paddr bit 2
    localparam int REG_IDX_BIT = 2;
    localparam logic REG_SPACE_LEVEL = 1'b0;
    localparam logic REG_TIMEOUT     = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_LEADER = 3'b010,
        PH_DATA   = 3'b100
    } phase_t;

    typedef struct packed {
        logic             space_level;
        logic [RUN_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] address_inv;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] command_inv;
        logic [REP_W-1:0]  repeat_count;
        logic [BCNT_W-1:0] bits_received;
        logic              frame_valid;
        logic              repeat_seen;
        logic              frame_finished;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/necir_if.sv @@
// Valid/ready channel interfaces for line samples and decode results.
`default_nettype none

interface necir_in_if
    import necir_pkg::*;
;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink   (input valid, input line_level, output ready);
endinterface

interface necir_out_if
    import necir_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] address_inv;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] command_inv;
    logic [REP_W-1:0]  repeat_count;
    logic [BCNT_W-1:0] bits_received;
    logic              frame_valid;
    logic              repeat_seen;
    logic              frame_finished;

    modport source (output valid, output address, output address_inv, output command,
                    output command_inv, output repeat_count, output bits_received,
                    output frame_valid, output repeat_seen, output frame_finished,
                    input ready);
    modport sink   (input valid, input address, input address_inv, input command,
                    input command_inv, input repeat_count, input bits_received,
                    input frame_valid, input repeat_seen, input frame_finished,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/nec_ir_frame_decoder.sv @@
// NEC IR frame decoder top level: channels, APB registers, result register.
//
// Usage:
//   in_ch carries one sampled IR line level per 100 us tick (valid/ready).
//   out_ch returns one result per sample: the four data bytes so far, the
//   repeat count, the bit count and the frame_valid / repeat_seen /
//   frame_finished pulses for that tick.
//   The APB port holds space_level (0x0) and timeout_ticks (0x4); write
//   them only while no transaction is in flight.
// Throughput: one sample per cycle is sustained unless out_ch stalls.
//   A result appears on out_ch in the cycle after its sample transaction.
//   The decode update is a single pass of counter and window compare
//   logic ahead of the result register.
// Reset:
//   rst_n clears all decode state and the result register and loads
//   space_level 1, timeout_ticks 1200.
// Stall:
//   While out_ch is stalled the result holds; in_ch.ready stays high as
//   long as the result register is empty or drains in the same cycle.
`default_nettype none

module nec_ir_frame_decoder
    import necir_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    necir_in_if.sink                in_ch,
    necir_out_if.source             out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    cfg_t    cfg_reg;
    result_t result_next;
    result_t result_reg;
    logic    out_valid_reg;
    logic    in_accept;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.space_level   <= 1'b1;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[REG_IDX_BIT])
                REG_SPACE_LEVEL: cfg_reg.space_level   <= pwdata[0];
                REG_TIMEOUT:     cfg_reg.timeout_ticks <= pwdata[RUN_W-1:0];
                default:         cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_IDX_BIT])
            REG_SPACE_LEVEL: prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.space_level};
            REG_TIMEOUT:     prdata = {{(PDATA_W-RUN_W){1'b0}}, cfg_reg.timeout_ticks};
            default:         prdata = '0;
        endcase
    end

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    necir_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .line_level (in_ch.line_level),
        .cfg        (cfg_reg),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.address        = result_reg.address;
    assign out_ch.address_inv    = result_reg.address_inv;
    assign out_ch.command        = result_reg.command;
    assign out_ch.command_inv    = result_reg.command_inv;
    assign out_ch.repeat_count   = result_reg.repeat_count;
    assign out_ch.bits_received  = result_reg.bits_received;
    assign out_ch.frame_valid    = result_reg.frame_valid;
    assign out_ch.repeat_seen    = result_reg.repeat_seen;
    assign out_ch.frame_finished = result_reg.frame_finished;

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_ch.valid)
        else $error("accepted sample produced no result");

    a_valid_finish_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.frame_valid && out_ch.frame_finished))
        else $error("frame_valid and frame_finished in one transaction");

    a_valid_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.frame_valid) |-> (out_ch.bits_received == BITS_FULL))
        else $error("frame_valid without a full bit count");

    a_finish_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.frame_finished) |->
            (out_ch.bits_received == '0 && out_ch.repeat_count == '0))
        else $error("frame_finished without cleared decode state");
`endif

endmodule

`default_nettype wire

@@ rtl/necir_core.sv @@
// Decode state and per-tick next-state / result logic.
`default_nettype none

module necir_core
    import necir_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    accept,
    input  wire logic    line_level,
    input  wire cfg_t    cfg,
    output result_t      result
);

    logic [RUN_W-1:0]  space_run_reg, space_run_next;
    logic [RUN_W-1:0]  burst_run_reg, burst_run_next;
    phase_t            phase_reg, phase_next;
    logic [BCNT_W-1:0] bit_count_reg, bit_count_next;
    logic              rpt_pend_reg, rpt_pend_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [REP_W-1:0]  repeats_reg, repeats_next;

    logic is_space;
    logic lead_burst;
    logic win_zero, win_one, win_rpt, win_hdr;
    logic bit_ok;
    logic valid_flag, rep_flag, fin_flag;

    assign is_space   = (line_level == cfg.space_level);
    assign lead_burst = (burst_run_reg >= LEAD_MIN) && (burst_run_reg <= LEAD_MAX);
    assign win_zero   = (space_run_reg >= ZERO_MIN) && (space_run_reg <= ZERO_MAX);
    assign win_one    = (space_run_reg >= ONE_MIN) && (space_run_reg <= ONE_MAX);
    assign win_rpt    = (space_run_reg >= RPT_MIN) && (space_run_reg <= RPT_MAX);
    assign win_hdr    = (space_run_reg >= HDR_MIN) && (space_run_reg <= HDR_MAX);
    assign bit_ok     = (phase_reg == PH_DATA) && (bit_count_reg < BITS_FULL);

    always_comb
    begin
        space_run_next = space_run_reg;
        burst_run_next = burst_run_reg;
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        rpt_pend_next  = rpt_pend_reg;
        data_next      = data_reg;
        repeats_next   = repeats_reg;
        valid_flag     = 1'b0;
        rep_flag       = 1'b0;
        fin_flag       = 1'b0;

        if (is_space)
        begin
            if (space_run_reg != RUN_MAX)
            begin
                space_run_next = space_run_reg + 1'b1;
            end
            if (lead_burst)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = PH_LEADER;
                end
                else if (phase_reg == PH_DATA && !rpt_pend_reg)
                begin
                    rpt_pend_next = 1'b1;
                end
            end
            burst_run_next = '0;
        end
        else
        begin
            if (burst_run_reg != RUN_MAX)
            begin
                burst_run_next = burst_run_reg + 1'b1;
            end
            if (win_zero || win_one)
            begin
                if (bit_ok)
                begin
                    if (win_one)
                    begin
                        data_next = data_reg | (DATA_W'(1) << bit_count_reg[4:0]);
                    end
                    bit_count_next = bit_count_reg + 1'b1;
                    valid_flag     = (bit_count_next == BITS_FULL);
                end
            end
            else if (win_rpt)
            begin
                if (rpt_pend_reg)
                begin
                    if (repeats_reg != REP_MAX)
                    begin
                        repeats_next = repeats_reg + 1'b1;
                    end
                    rpt_pend_next = 1'b0;
                    rep_flag      = 1'b1;
                end
            end
            else if (win_hdr)
            begin
                if (phase_reg == PH_LEADER)
                begin
                    phase_next = PH_DATA;
                end
            end
            space_run_next = '0;
        end

        if (space_run_next > cfg.timeout_ticks)
        begin
            fin_flag       = (bit_count_next == BITS_FULL);
            space_run_next = '0;
            burst_run_next = '0;
            phase_next     = PH_IDLE;
            bit_count_next = '0;
            rpt_pend_next  = 1'b0;
            data_next      = '0;
            repeats_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_run_reg <= '0;
            burst_run_reg <= '0;
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            rpt_pend_reg  <= 1'b0;
            data_reg      <= '0;
            repeats_reg   <= '0;
        end
        else if (accept)
        begin
            space_run_reg <= space_run_next;
            burst_run_reg <= burst_run_next;
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            rpt_pend_reg  <= rpt_pend_next;
            data_reg      <= data_next;
            repeats_reg   <= repeats_next;
        end
    end

    assign result.address        = data_next[7:0];
    assign result.address_inv    = data_next[15:8];
    assign result.command        = data_next[23:16];
    assign result.command_inv    = data_next[31:24];
    assign result.repeat_count   = repeats_next;
    assign result.bits_received  = bit_count_next;
    assign result.frame_valid    = valid_flag;
    assign result.repeat_seen    = rep_flag;
    assign result.frame_finished = fin_flag;

endmodule

`default_nettype wire

@@ tb/sv/tb_nec_ir_frame_decoder.sv @@
// Self-checking testbench for the NEC IR frame decoder: frames, repeats, noise and stalls.
`default_nettype none

module tb_nec_ir_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import necir_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_TICKS   = 15000;
    localparam int MAX_REPORTS    = 10;

    localparam int LEADER_LO      = 80;
    localparam int LEADER_HI      = 100;
    localparam int ZERO_LO        = 3;
    localparam int ZERO_HI        = 8;
    localparam int ONE_LO         = 15;
    localparam int ONE_HI         = 19;
    localparam int RPT_LO         = 20;
    localparam int RPT_HI         = 25;
    localparam int HDR_LO         = 42;
    localparam int HDR_HI         = 48;
    localparam int BITS_PER_FRAME = 32;
    localparam logic [10:0] RUN_SAT         = 11'd2047;
    localparam logic [10:0] TIMEOUT_DEFAULT = 11'd1200;
    localparam logic [7:0]  RPT_SAT         = 8'd255;

    localparam bit RUN_SPACE = 1'b0;
    localparam bit RUN_BURST = 1'b1;

    localparam logic [PADDR_W-1:0] A_SPACE_LEVEL = PADDR_W'(REG_SPACE_LEVEL) << REG_IDX_BIT;
    localparam logic [PADDR_W-1:0] A_TIMEOUT     = PADDR_W'(REG_TIMEOUT) << REG_IDX_BIT;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    necir_in_if  in_ch();
    necir_out_if out_ch();

    nec_ir_frame_decoder u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // decoder shadow state
    logic        cfg_space_level;
    logic [10:0] cfg_timeout;
    logic [10:0] space_run;
    logic [10:0] burst_run;
    phase_t      ph;
    logic [5:0]  bit_cnt;
    logic        rpt_pending;
    logic [7:0]  dbytes [4];
    logic [7:0]  rpt_cnt;
    result_t     decode_q [$];

    bit   tx_idle_en = 1'b1;
    bit   rx_idle_en = 1'b1;
    bit   edge_lens = 1'b0;
    bit   broken = 1'b0;
    int   hold_reqs = 0;
    int   ticks_sent = 0;
    int   fail_count = 0;
    int   results_checked = 0;
    int   frames_seen = 0;
    int   repeats_seen = 0;
    int   finishes_seen = 0;
    logic [7:0] max_rpt = '0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic void clear_decoder();
        space_run   = '0;
        burst_run   = '0;
        ph          = PH_IDLE;
        bit_cnt     = '0;
        rpt_pending = 1'b0;
        rpt_cnt     = '0;
        foreach (dbytes[i]) dbytes[i] = '0;
    endfunction

    function automatic bit in_win(input logic [10:0] v, input int lo, input int hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic result_t decode_tick(input logic lvl);
        result_t r;
        r = '0;
        if (lvl == cfg_space_level)
        begin
            if (space_run != RUN_SAT) space_run = space_run + 1'b1;
            if (in_win(burst_run, LEADER_LO, LEADER_HI))
            begin
                if (ph == PH_IDLE)
                    ph = PH_LEADER;
                else if (ph == PH_DATA && !rpt_pending)
                    rpt_pending = 1'b1;
            end
            burst_run = '0;
        end
        else
        begin
            if (burst_run != RUN_SAT) burst_run = burst_run + 1'b1;
            if (in_win(space_run, ZERO_LO, ZERO_HI) || in_win(space_run, ONE_LO, ONE_HI))
            begin
                if (ph == PH_DATA && bit_cnt < BITS_PER_FRAME)
                begin
                    if (space_run >= ONE_LO) dbytes[bit_cnt[4:3]][bit_cnt[2:0]] = 1'b1;
                    bit_cnt = bit_cnt + 1'b1;
                    r.frame_valid = (bit_cnt == BITS_PER_FRAME);
                end
            end
            else if (in_win(space_run, RPT_LO, RPT_HI))
            begin
                if (rpt_pending)
                begin
                    if (rpt_cnt != RPT_SAT) rpt_cnt = rpt_cnt + 1'b1;
                    rpt_pending   = 1'b0;
                    r.repeat_seen = 1'b1;
                end
            end
            else if (in_win(space_run, HDR_LO, HDR_HI))
            begin
                if (ph == PH_LEADER) ph = PH_DATA;
            end
            space_run = '0;
        end
        if (space_run > cfg_timeout)
        begin
            r.frame_finished = (bit_cnt == BITS_PER_FRAME);
            clear_decoder();
        end
        r.address       = dbytes[0];
        r.address_inv   = dbytes[1];
        r.command       = dbytes[2];
        r.command_inv   = dbytes[3];
        r.repeat_count  = rpt_cnt;
        r.bits_received = bit_cnt;
        return r;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("a=%02h ai=%02h c=%02h ci=%02h rc=%0d bits=%0d fv=%b rs=%b ff=%b",
                         r.address, r.address_inv, r.command, r.command_inv, r.repeat_count,
                         r.bits_received, r.frame_valid, r.repeat_seen, r.frame_finished);
    endfunction

    function automatic logic [31:0] nec_word(input logic [7:0] addr, input logic [7:0] cmd);
        return {~cmd, cmd, ~addr, addr};
    endfunction

    function automatic int pick_len(input int lo, input int hi);
        if (edge_lens) return $urandom_range(1, 0) ? hi : lo;
        if (broken && $urandom_range(19, 0) == 0) return $urandom_range(60, 1);
        return $urandom_range(hi, lo);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        got.address        = out_ch.address;
        got.address_inv    = out_ch.address_inv;
        got.command        = out_ch.command;
        got.command_inv    = out_ch.command_inv;
        got.repeat_count   = out_ch.repeat_count;
        got.bits_received  = out_ch.bits_received;
        got.frame_valid    = out_ch.frame_valid;
        got.repeat_seen    = out_ch.repeat_seen;
        got.frame_finished = out_ch.frame_finished;
        if (decode_q.size() == 0)
        begin
            note_failure($sformatf("unexpected result %s", fmt_result(got)));
            return;
        end
        want = decode_q.pop_front();
        results_checked++;
        if (got !== want)
            note_failure($sformatf("result %0d: expected %s, got %s", results_checked,
                                   fmt_result(want), fmt_result(got)));
        frames_seen   += got.frame_valid;
        repeats_seen  += got.repeat_seen;
        finishes_seen += got.frame_finished;
        if (got.repeat_count > max_rpt) max_rpt = got.repeat_count;
    endtask

    // result side: random stalls, long holds on request, checks every transaction
    initial
    begin : result_sink
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) check_result();
            if (hold_reqs != holds_served)
            begin
                holds_served++;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && rx_idle_en && $urandom_range(99, 0) < 3)
                stall_left = $urandom_range(30, 8);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(99, 0) < 20)
                out_ch.ready <= 1'b0;
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: %0d cycles without a transaction", idle);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_tick(input logic lvl);
        int gap;
        gap = 0;
        if (tx_idle_en)
        begin
            case ($urandom_range(19, 0))
                0, 1, 2, 3:  gap = $urandom_range(3, 1);
                4:           gap = $urandom_range(30, 8);
                default:     gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.line_level <= lvl;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        decode_q.push_back(decode_tick(lvl));
        ticks_sent++;
    endtask

    task automatic send_run(input bit kind, input int n);
        repeat (n) send_tick(kind == RUN_BURST ? ~cfg_space_level : cfg_space_level);
    endtask

    task automatic send_leader();
        send_run(RUN_BURST, pick_len(LEADER_LO, LEADER_HI));
        send_run(RUN_SPACE, pick_len(HDR_LO, HDR_HI));
    endtask

    task automatic send_bits(input logic [31:0] data, input int n);
        for (int i = 0; i < n; i++)
        begin
            send_run(RUN_BURST, pick_len(1, 6));
            if (data[i % 32])
                send_run(RUN_SPACE, pick_len(ONE_LO, ONE_HI));
            else
                send_run(RUN_SPACE, pick_len(ZERO_LO, ZERO_HI));
        end
        send_run(RUN_BURST, pick_len(1, 6));
    endtask

    task automatic send_frame(input logic [31:0] data, input int n);
        send_leader();
        send_bits(data, n);
    endtask

    task automatic send_repeat();
        send_run(RUN_SPACE, pick_len(26, 40));
        send_run(RUN_BURST, pick_len(LEADER_LO, LEADER_HI));
        send_run(RUN_SPACE, pick_len(RPT_LO, RPT_HI));
        send_run(RUN_BURST, pick_len(1, 6));
    endtask

    task automatic end_frame();
        send_run(RUN_SPACE, int'(cfg_timeout) + 1 + $urandom_range(3, 0));
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (decode_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] rd;
        logic [PDATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr == A_SPACE_LEVEL)
            cfg_space_level = data[0];
        else
            cfg_timeout = data[10:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        want = (addr == A_SPACE_LEVEL) ? PDATA_W'(cfg_space_level) : PDATA_W'(cfg_timeout);
        if (rd !== want)
            note_failure($sformatf("register 0x%0h read %0h, expected %0h", addr, rd, want));
    endtask

    task automatic set_config(input logic lvl, input logic [10:0] tmo);
        settle();
        write_reg(A_SPACE_LEVEL, ($urandom() & ~32'h1) | PDATA_W'(lvl));
        write_reg(A_TIMEOUT, ($urandom() & ~32'h7FF) | PDATA_W'(tmo));
    endtask

    task automatic test_registers();
        set_config(1'b0, 11'd1);
        set_config(1'b1, 11'd2000);
        set_config(1'b1, TIMEOUT_DEFAULT);
    endtask

    task automatic test_clean_frames();
        send_frame(32'hFFFF_FFFF, 32);
        end_frame();
        // last bit a zero must still flag the frame
        send_frame(32'h0000_0000, 32);
        send_repeat();
        end_frame();
        send_frame(nec_word(8'h00, 8'h5A), 32);
        end_frame();
    endtask

    task automatic test_window_edges();
        int lead_b [4] = '{79, 101, 90, 90};
        int lead_s [4] = '{44, 44, 41, 49};
        int odd_space [7] = '{2, 9, 14, 20, 26, 41, 49};
        set_config(1'b1, 11'd60);
        edge_lens = 1'b1;
        repeat (4)
        begin
            send_frame($urandom(), 32);
            send_repeat();
            end_frame();
        end
        edge_lens = 1'b0;
        foreach (lead_b[i])
        begin
            send_run(RUN_BURST, lead_b[i]);
            send_run(RUN_SPACE, lead_s[i]);
            send_bits(32'hFFFF_FFFF, 4);
            end_frame();
        end
        send_leader();
        foreach (odd_space[i])
        begin
            send_run(RUN_BURST, 2);
            send_run(RUN_SPACE, odd_space[i]);
        end
        send_run(RUN_BURST, 90);
        send_run(RUN_SPACE, 26);
        send_bits($urandom(), 3);
        end_frame();
        // space of exactly the timeout keeps the frame going
        send_frame($urandom(), 8);
        send_run(RUN_SPACE, 60);
        send_bits($urandom(), 24);
        end_frame();
    endtask

    task automatic test_extra_bits();
        send_frame($urandom(), 32);
        send_bits($urandom(), 5);
        end_frame();
    endtask

    task automatic test_repeats();
        send_frame(nec_word(8'hA5, 8'h3C), 32);
        repeat (3) send_repeat();
        end_frame();
        // leader plus repeat space in the middle of the data
        send_frame($urandom(), 10);
        send_run(RUN_BURST, 90);
        send_run(RUN_SPACE, 22);
        send_bits($urandom(), 22);
        end_frame();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_frame($urandom(), 32);
        repeat (260)
        begin
            send_run(RUN_BURST, 80);
            send_run(RUN_SPACE, 20);
        end
        send_run(RUN_BURST, 1);
        end_frame();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_timeouts();
        send_frame($urandom(), 10);
        end_frame();
        set_config(1'b0, 11'd1);
        repeat (40) send_run(1'($urandom_range(1, 0)), $urandom_range(5, 1));
        set_config(1'b1, 11'd2000);
        send_frame($urandom(), 32);
        end_frame();
    endtask

    task automatic test_burst_saturation();
        set_config(1'b1, 11'd60);
        // a wrapping counter would see a leader here
        send_run(RUN_BURST, 2048 + 85);
        send_run(RUN_SPACE, 44);
        send_bits(32'hFFFF_FFFF, 8);
        end_frame();
    endtask

    task automatic test_inverted_level();
        set_config(1'b0, 11'd80);
        send_frame(nec_word(8'h81, 8'h7E), 32);
        send_repeat();
        end_frame();
        send_frame($urandom(), 32);
        end_frame();
    endtask

    task automatic test_backpressure();
        set_config(1'b1, 11'd60);
        tx_idle_en = 1'b0;
        hold_reqs++;
        send_frame($urandom(), 32);
        send_repeat();
        end_frame();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        int start;
        int kind;
        int r;
        logic [10:0] tmo;
        logic [31:0] word;
        start = ticks_sent;
        while (ticks_sent - start < RANDOM_TICKS)
        begin
            if ($urandom_range(3, 0) == 0)
            begin
                r = $urandom_range(9, 0);
                if (r == 0)
                    tmo = 11'($urandom_range(48, 1));
                else if (r == 1)
                    tmo = 11'($urandom_range(2000, 1200));
                else
                    tmo = 11'($urandom_range(200, 49));
                set_config(1'($urandom_range(1, 0)), tmo);
            end
            tx_idle_en = ($urandom_range(3, 0) != 0);
            rx_idle_en = ($urandom_range(3, 0) != 0);
            edge_lens  = ($urandom_range(9, 0) == 0);
            word = $urandom_range(1, 0) ? nec_word(8'($urandom()), 8'($urandom())) : $urandom();
            kind = $urandom_range(99, 0);
            if (kind < 60)
            begin
                send_frame(word, 32);
                repeat ($urandom_range(3, 0)) send_repeat();
                end_frame();
            end
            else if (kind < 75)
            begin
                broken = 1'b1;
                send_frame(word, $urandom_range(33, 0));
                if ($urandom_range(1, 0)) send_repeat();
                end_frame();
                broken = 1'b0;
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(12, 2))
                    send_run(1'($urandom_range(1, 0)), $urandom_range(120, 1));
                repeat ($urandom_range(40, 0)) send_tick(1'($urandom_range(1, 0)));
            end
            else
            begin
                send_leader();
                send_repeat();
                send_run(RUN_SPACE, $urandom_range(50, 1));
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        edge_lens  = 1'b0;
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.line_level <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        cfg_space_level = 1'b1;
        cfg_timeout     = TIMEOUT_DEFAULT;
        clear_decoder();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_clean_frames();
        test_registers();
        test_window_edges();
        test_extra_bits();
        test_repeats();
        test_timeouts();
        test_burst_saturation();
        test_inverted_level();
        test_backpressure();
        test_random_traffic();

        settle();
        $display("Sent %0d line samples, checked %0d results: %0d frames, %0d repeat codes,",
                 ticks_sent, results_checked, frames_seen, repeats_seen);
        $display("%0d finished frames, peak repeat count %0d, %0d failures",
                 finishes_seen, max_rpt, fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
